FILE: rtl/tgr_pkg.sv
// Shared types and constants for the text glyph rasteriser.
package tgr_pkg;

    // Input word kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_FONT  = 2'd2;

    // Character codes with a special meaning.
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] FIRST_GLYPH  = 8'd32;

    // Geometry of the font store and of the cursor.
    localparam int         FONT_DEPTH     = 768;
    localparam int         FONT_AW        = 10;
    localparam int         FONT_GLYPHS    = FONT_DEPTH / 8;
    localparam int         GLYPH_W        = 7;
    localparam int         COORD_W        = 11;
    localparam logic [10:0] COORD_MAX     = 11'h7FF;
    localparam logic [5:0] GLYPH_STEP     = 6'd8;
    localparam logic [5:0] TAB_STEP       = 6'd32;
    localparam int         COLOR_W        = 24;
    localparam int         OFFSET_W       = 20;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;         // input word accepted this cycle
        logic start_fetch;  // read the first font row of the glyph
        logic emit;         // load the next pixel word into the output register
    } tgr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic glyph_item;   // the presented input word renders a glyph
        logic pixel_last;   // the next pixel to emit is the 64th
        logic slot_free;    // the output register can take a word
    } tgr_stat_t;

    // Add with saturation at the largest coordinate.
    function automatic logic [10:0] sat_add(input logic [10:0] a, input logic [5:0] b);
        logic [11:0] s;
        s = {1'b0, a} + 12'(b);
        sat_add = s[11] ? COORD_MAX : s[10:0];
    endfunction

endpackage

FILE: rtl/tgr_ctrl.sv
// Controller state machine that sequences input words and glyph pixels.
module tgr_ctrl
    import tgr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  tgr_stat_t stat,
    output tgr_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_PIXEL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next      = state_reg;
        cmd.take        = 1'b0;
        cmd.start_fetch = 1'b0;
        cmd.emit        = 1'b0;
        in_stall        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                if (in_valid && stat.glyph_item)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.start_fetch = 1'b1;
                state_next      = ST_PIXEL;
            end
            ST_PIXEL:
            begin
                cmd.emit = stat.slot_free;
                if (stat.slot_free && stat.pixel_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/tgr_datapath.sv
// Datapath: cursor state, font memory, pixel address arithmetic and output register.
module tgr_datapath
    import tgr_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 240,
    parameter int SCREEN_WIDTH  = 400,
    parameter int GLYPH_COUNT   = 96
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgr_cmd_t             cmd,
    output tgr_stat_t            stat,
    input  logic [1:0]           kind,
    input  logic [COORD_W-1:0]   start_x,
    input  logic [COORD_W-1:0]   start_y,
    input  logic [COLOR_W-1:0]   text_color,
    input  logic [7:0]           char_code,
    input  logic [FONT_AW-1:0]   font_index,
    input  logic [7:0]           font_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OFFSET_W-1:0]  pixel_offset,
    output logic [COLOR_W-1:0]   pixel_color,
    output logic                 off_screen,
    output logic                 last,
    output logic [COORD_W-1:0]   cursor_after
);

    // Glyphs whose eight rows lie wholly inside the font store.
    localparam int GLYPH_LIMIT = (GLYPH_COUNT < FONT_GLYPHS) ? GLYPH_COUNT : FONT_GLYPHS;

    logic [COORD_W-1:0]  cursor_x_reg;
    logic [COORD_W-1:0]  cursor_y_reg;
    logic [COORD_W-1:0]  origin_x_reg;
    logic [COLOR_W-1:0]  fg_color_reg;
    logic [GLYPH_W-1:0]  glyph_reg;
    logic                glyph_ok_reg;
    logic [5:0]          pix_cnt_reg;
    logic [7:0]          font_mem [FONT_DEPTH];
    logic [7:0]          rd_data_reg;
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic                off_reg;
    logic                last_reg;
    logic [COORD_W-1:0]  after_reg;

    logic [7:0]          glyph_idx;
    logic                glyph_ok;
    logic                font_we;
    logic                font_re;
    logic [FONT_AW-1:0]  rd_addr;
    logic [2:0]          row;
    logic [2:0]          col;
    logic [11:0]         px;
    logic [11:0]         py;
    logic                off;
    logic [23:0]         lin;
    logic [23:0]         lin3;
    logic [COORD_W-1:0]  after;

    // Decode of the presented input word.
    always_comb
    begin
        glyph_idx       = char_code - FIRST_GLYPH;
        glyph_ok        = (char_code >= FIRST_GLYPH) && (32'(glyph_idx) < GLYPH_LIMIT);
        font_we         = cmd.take && (kind == KIND_FONT) && (32'(font_index) < FONT_DEPTH);
    end

    assign stat.glyph_item = (kind == KIND_CHAR) && (char_code != CHAR_NEWLINE)
                             && (char_code != CHAR_TAB);

    // Pixel position within the glyph.
    assign row = pix_cnt_reg[5:3];
    assign col = pix_cnt_reg[2:0];

    // Font row reads: the first row at fetch, each later row as the previous one ends.
    always_comb
    begin
        font_re = 1'b0;
        rd_addr = {glyph_reg, 3'd0};
        if (cmd.start_fetch)
        begin
            font_re = 1'b1;
        end
        else if (cmd.emit && (col == 3'd7) && (row != 3'd7))
        begin
            font_re = 1'b1;
            rd_addr = {glyph_reg, row + 3'd1};
        end
    end

    // Font memory: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[font_index] <= font_byte;
        end
        if (font_re)
        begin
            rd_data_reg <= font_mem[rd_addr];
        end
    end

    // Screen position, clipping and byte offset of the current pixel.
    always_comb
    begin
        px    = {1'b0, cursor_x_reg} + 12'(col);
        py    = {1'b0, cursor_y_reg} + 12'(row);
        off   = (32'(px) >= SCREEN_WIDTH) || (32'(py) >= SCREEN_HEIGHT);
        lin   = 24'(px) * 24'(SCREEN_HEIGHT) + 24'(SCREEN_HEIGHT - 1) - 24'(py);
        lin3  = lin + {lin[22:0], 1'b0};
        after = sat_add(cursor_x_reg, GLYPH_STEP);
    end

    assign stat.pixel_last = (pix_cnt_reg == 6'd63);
    assign stat.slot_free  = !out_valid_reg || !out_stall;

    // Cursor, origin and colour state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            origin_x_reg <= '0;
            fg_color_reg <= '0;
        end
        else if (cmd.take && (kind == KIND_START))
        begin
            origin_x_reg <= start_x;
            cursor_x_reg <= start_x;
            cursor_y_reg <= start_y;
            fg_color_reg <= text_color;
        end
        else if (cmd.take && (kind == KIND_CHAR) && (char_code == CHAR_NEWLINE))
        begin
            cursor_x_reg <= origin_x_reg;
            cursor_y_reg <= sat_add(cursor_y_reg, GLYPH_STEP);
        end
        else if (cmd.take && (kind == KIND_CHAR) && (char_code == CHAR_TAB))
        begin
            cursor_x_reg <= sat_add(cursor_x_reg, TAB_STEP);
        end
        else if (cmd.emit && stat.pixel_last)
        begin
            cursor_x_reg <= after;
        end
    end

    // Glyph selection captured whenever an input word is taken; a character word's selection is the one used.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            glyph_reg    <= glyph_idx[GLYPH_W-1:0];
            glyph_ok_reg <= glyph_ok;
        end
    end

    // Pixel counter across the 64 pixels of a glyph.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg <= '0;
        end
        else if (cmd.start_fetch)
        begin
            pix_cnt_reg <= '0;
        end
        else if (cmd.emit)
        begin
            pix_cnt_reg <= pix_cnt_reg + 6'd1;
        end
    end

    // Output word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            offset_reg <= off ? '0 : lin3[OFFSET_W-1:0];
            color_reg  <= (glyph_ok_reg && rd_data_reg[~col]) ? fg_color_reg : '0;
            off_reg    <= off;
            last_reg   <= stat.pixel_last;
            after_reg  <= after;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_offset = offset_reg;
    assign pixel_color  = color_reg;
    assign off_screen   = off_reg;
    assign last         = last_reg;
    assign cursor_after = after_reg;

endmodule

FILE: rtl/text_glyph_rasterizer_core.sv
// Top level of the 8x8 bitmap text glyph rasteriser.
// A start, newline, tab or font load word is taken from the idle state and gives no output.
// A printable character is taken, then the first font row is read from the 768-byte
// font memory, then one pixel word is issued per cycle while the output side does not
// stall, for 64 pixels, row by row from the top, leftmost pixel first. Each later row
// is read while the last pixel of the row before it is issued. The input is stalled
// while a glyph is rendered, and the last pixel word waits in the output register
// while the next input word is taken. Codes with no glyph draw a blank cell, off-screen
// pixels are still issued with off_screen set and a zero offset, and mirroring into a
// second buffer is left to the consumer.
module text_glyph_rasterizer_core
    import tgr_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 240,
    parameter int SCREEN_WIDTH  = 400,
    parameter int GLYPH_COUNT   = 96
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [COORD_W-1:0]  start_x,
    input  logic [COORD_W-1:0]  start_y,
    input  logic [COLOR_W-1:0]  text_color,
    input  logic [7:0]          char_code,
    input  logic [FONT_AW-1:0]  font_index,
    input  logic [7:0]          font_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OFFSET_W-1:0] pixel_offset,
    output logic [COLOR_W-1:0]  pixel_color,
    output logic                off_screen,
    output logic                last,
    output logic [COORD_W-1:0]  cursor_after
);

    tgr_cmd_t  cmd;
    tgr_stat_t stat;

    // Sequencer.
    tgr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    tgr_datapath
    #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .GLYPH_COUNT   (GLYPH_COUNT)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .start_x      (start_x),
        .start_y      (start_y),
        .text_color   (text_color),
        .char_code    (char_code),
        .font_index   (font_index),
        .font_byte    (font_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_offset (pixel_offset),
        .pixel_color  (pixel_color),
        .off_screen   (off_screen),
        .last         (last),
        .cursor_after (cursor_after)
    );

endmodule

FILE: rtl/tgr_checker.sv
// Port-level checker for the text glyph rasteriser, bound to the top level.
module tgr_checker
    import tgr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [1:0]          kind,
    input logic [7:0]          char_code,
    input logic                out_valid,
    input logic                out_stall,
    input logic [OFFSET_W-1:0] pixel_offset,
    input logic [COLOR_W-1:0]  pixel_color,
    input logic                off_screen,
    input logic                last,
    input logic [COORD_W-1:0]  cursor_after
);

    // A stalled output word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_offset)
        && $stable(pixel_color) && $stable(off_screen) && $stable(last)
        && $stable(cursor_after))
    else $error("stalled output word changed");

    // Off-screen pixels carry a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && off_screen |-> pixel_offset == '0)
    else $error("off-screen pixel with non-zero offset");

    // A printable character holds the input off while it renders.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_CHAR && char_code != CHAR_NEWLINE
        && char_code != CHAR_TAB |=> in_stall)
    else $error("input taken during glyph rendering");

    // Two glyph-final words never follow each other directly.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !(out_valid && last))
    else $error("glyph ended with fewer than 64 pixels");

endmodule

bind text_glyph_rasterizer_core tgr_checker u_tgr_checker (.*);

FILE: tb/text_glyph_rasterizer_core_test.sv
// Self-checking testbench for the text glyph rasteriser core, with a predicting scoreboard.
`timescale 1ns / 100ps

module text_glyph_rasterizer_core_test;
    import tgr_pkg::*;

    localparam int SCR_H        = 240;
    localparam int SCR_W        = 400;
    localparam int GLYPHS       = 96;
    localparam int RANDOM_WORDS = 90;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;

    // The fourth kind code has no meaning and must be dropped by the block.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Row patterns for the glyph of '!': full, empty, single edge bits, alternating, both edges, inner six.
    localparam logic [7:0] ROW_PATTERN [8] = '{8'hFF, 8'h00, 8'h80, 8'h01,
                                               8'hAA, 8'h55, 8'h81, 8'h7E};

    // One input word, every field present whatever the kind.
    typedef struct packed {
        logic [1:0]          kind;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic [COLOR_W-1:0]  colour;
        logic [7:0]          code;
        logic [FONT_AW-1:0]  fidx;
        logic [7:0]          fbyte;
    } text_word_t;

    // One pixel write, in the order of the output ports.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [COLOR_W-1:0]  colour;
        logic                off_screen;
        logic                last;
        logic [COORD_W-1:0]  cursor;
    } pixel_word_t;

    // Tracks the cursor, colour and font store, and holds the pixel writes still owed.
    class glyph_scoreboard;
        bit [COORD_W-1:0] cursor_x;
        bit [COORD_W-1:0] cursor_y;
        bit [COORD_W-1:0] origin_x;
        bit [COLOR_W-1:0] fg_colour;
        bit [7:0]         font_mem [FONT_DEPTH];
        pixel_word_t      pending [$];
        int               errors;

        function bit [COORD_W-1:0] clamp_add(bit [COORD_W-1:0] a, int step);
            int total;
            total = int'(a) + step;
            return (total > int'(COORD_MAX)) ? COORD_MAX : total[COORD_W-1:0];
        endfunction

        // Lays out the 64 pixel writes of one character cell, top row first.
        function void draw_cell(bit [7:0] code);
            int               g;
            int               px;
            int               py;
            int               byte_pos;
            bit               drawn;
            bit [7:0]         bits;
            bit [COORD_W-1:0] after;
            pixel_word_t      p;
            g = int'(code) - int'(FIRST_GLYPH);
            drawn = (g >= 0) && (g < GLYPHS) && (g * 8 + 8 <= FONT_DEPTH);
            after = clamp_add(cursor_x, int'(GLYPH_STEP));
            for (int row = 0; row < 8; row++)
            begin
                bits = drawn ? font_mem[g * 8 + row] : 8'h00;
                for (int col = 0; col < 8; col++)
                begin
                    px = int'(cursor_x) + col;
                    py = int'(cursor_y) + row;
                    p.off_screen = (px >= SCR_W) || (py >= SCR_H);
                    byte_pos = ((SCR_H - py - 1) + px * SCR_H) * 3;
                    p.offset = p.off_screen ? '0 : byte_pos[OFFSET_W-1:0];
                    p.colour = bits[7 - col] ? fg_colour : '0;
                    p.last = (row == 7) && (col == 7);
                    p.cursor = after;
                    pending.push_back(p);
                end
            end
            cursor_x = after;
        endfunction

        // Applies one accepted input word to the predicted state.
        function void note_word(text_word_t w);
            case (w.kind)
                KIND_START:
                begin
                    origin_x = w.start_x;
                    cursor_x = w.start_x;
                    cursor_y = w.start_y;
                    fg_colour = w.colour;
                end
                KIND_CHAR:
                begin
                    if (w.code == CHAR_NEWLINE)
                    begin
                        cursor_x = origin_x;
                        cursor_y = clamp_add(cursor_y, int'(GLYPH_STEP));
                    end
                    else if (w.code == CHAR_TAB)
                        cursor_x = clamp_add(cursor_x, int'(TAB_STEP));
                    else
                        draw_cell(w.code);
                end
                KIND_FONT:
                begin
                    if (int'(w.fidx) < FONT_DEPTH)
                        font_mem[w.fidx] = w.fbyte;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        // Compares one accepted pixel word with the oldest one owed.
        task check_pixel(pixel_word_t got);
            pixel_word_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("pixel word with none owed, offset %0d", got.offset));
                return;
            end
            want = pending.pop_front();
            if (got.offset !== want.offset)
                report_mismatch($sformatf("pixel_offset %0d, predicted %0d",
                                          got.offset, want.offset));
            if (got.colour !== want.colour)
                report_mismatch($sformatf("pixel_color %06h, predicted %06h",
                                          got.colour, want.colour));
            if (got.off_screen !== want.off_screen)
                report_mismatch($sformatf("off_screen %b, predicted %b",
                                          got.off_screen, want.off_screen));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, predicted %b", got.last, want.last));
            if (got.cursor !== want.cursor)
                report_mismatch($sformatf("cursor_after %0d, predicted %0d",
                                          got.cursor, want.cursor));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          kind = KIND_START;
    logic [COORD_W-1:0]  start_x = '0;
    logic [COORD_W-1:0]  start_y = '0;
    logic [COLOR_W-1:0]  text_color = '0;
    logic [7:0]          char_code = '0;
    logic [FONT_AW-1:0]  font_index = '0;
    logic [7:0]          font_byte = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [OFFSET_W-1:0] pixel_offset;
    logic [COLOR_W-1:0]  pixel_color;
    logic                off_screen;
    logic                last;
    logic [COORD_W-1:0]  cursor_after;

    int tx_idle_pct = 35;
    int rx_idle_pct = 60;
    int cycle_count = 0;

    glyph_scoreboard sb;

    text_glyph_rasterizer_core #(
        .SCREEN_HEIGHT (SCR_H),
        .SCREEN_WIDTH  (SCR_W),
        .GLYPH_COUNT   (GLYPHS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .start_x      (start_x),
        .start_y      (start_y),
        .text_color   (text_color),
        .char_code    (char_code),
        .font_index   (font_index),
        .font_byte    (font_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_offset (pixel_offset),
        .pixel_color  (pixel_color),
        .off_screen   (off_screen),
        .last         (last),
        .cursor_after (cursor_after)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit, well beyond the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The pixel side stalls at random, set at the falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Every accepted pixel word goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel({pixel_offset, pixel_color, off_screen, last, cursor_after});
    end

    // Fills every field at random so unused fields never hold still.
    function automatic text_word_t random_word();
        text_word_t w;
        w.kind = 2'($urandom_range(0, 3));
        w.start_x = COORD_W'($urandom);
        w.start_y = COORD_W'($urandom);
        w.colour = COLOR_W'($urandom);
        w.code = 8'($urandom);
        w.fidx = FONT_AW'($urandom);
        w.fbyte = 8'($urandom);
        return w;
    endfunction

    // Presents one word after a random gap and holds it until the block takes it.
    task automatic send_word(text_word_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= w.kind;
        start_x <= w.start_x;
        start_y <= w.start_y;
        text_color <= w.colour;
        char_code <= w.code;
        font_index <= w.fidx;
        font_byte <= w.fbyte;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic send_start(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COLOR_W-1:0] colour);
        text_word_t w;
        w = random_word();
        w.kind = KIND_START;
        w.start_x = x;
        w.start_y = y;
        w.colour = colour;
        send_word(w);
    endtask

    task automatic send_char(logic [7:0] code);
        text_word_t w;
        w = random_word();
        w.kind = KIND_CHAR;
        w.code = code;
        send_word(w);
    endtask

    task automatic send_font(logic [FONT_AW-1:0] idx, logic [7:0] value);
        text_word_t w;
        w = random_word();
        w.kind = KIND_FONT;
        w.fidx = idx;
        w.fbyte = value;
        send_word(w);
    endtask

    initial
    begin
        text_word_t w;
        int         sent;
        int         choice;
        int         g;
        int         ready_glyphs [$];

        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: a blank cell straight out of reset, with the colour still black.
        send_char(8'd0);

        // Load the glyph for '!' with edge and alternating row patterns.
        for (int r = 0; r < 8; r++)
            send_font(FONT_AW'(8 + r), ROW_PATTERN[r]);
        ready_glyphs.push_back(1);

        // Out-of-range load is dropped; the last byte of the store is written.
        send_font(FONT_AW'(1023), 8'h5A);
        send_font(FONT_AW'(FONT_DEPTH - 1), 8'hA5);

        // Top-left corner, white, with tab and newline between glyphs.
        send_start('0, '0, 24'hFFFFFF);
        send_char(8'd33);
        send_char(CHAR_TAB);
        send_char(8'd33);
        send_char(CHAR_NEWLINE);
        send_char(8'd33);

        // Cell straddling the bottom-right corner of the screen.
        send_start(COORD_W'(SCR_W - 4), COORD_W'(SCR_H - 4), 24'h123456);
        send_char(8'd33);

        // Cursor at its ceiling: every pixel off screen, movement saturates.
        send_start(COORD_MAX, COORD_MAX, 24'hC0FFEE);
        send_char(8'd33);
        send_char(CHAR_NEWLINE);
        send_char(CHAR_TAB);
        send_char(8'd255);
        w = random_word();
        w.kind = KIND_UNUSED;
        send_word(w);

        // Random part: mostly text on or near the screen, with font loads and noise.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent >= 60)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (sent >= 30)
            begin
                tx_idle_pct = 60;
                rx_idle_pct = 35;
            end
            choice = $urandom_range(0, 99);
            if (choice < 12)
            begin
                // A whole glyph, so that it may be drawn afterwards.
                g = $urandom_range(0, GLYPHS - 1);
                for (int r = 0; r < 8; r++)
                    send_font(FONT_AW'(g * 8 + r), 8'($urandom));
                ready_glyphs.push_back(g);
                sent += 8;
            end
            else if (choice < 22)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_start(COORD_W'($urandom), COORD_W'($urandom), COLOR_W'($urandom));
                else
                    send_start(COORD_W'($urandom_range(0, SCR_W + 8)),
                               COORD_W'($urandom_range(0, SCR_H + 8)), COLOR_W'($urandom));
                sent++;
            end
            else if (choice < 30)
            begin
                send_char(CHAR_NEWLINE);
                sent++;
            end
            else if (choice < 36)
            begin
                send_char(CHAR_TAB);
                sent++;
            end
            else if (choice < 46)
            begin
                // Codes with no glyph draw a blank cell.
                case ($urandom_range(0, 2))
                    0:       send_char(8'($urandom_range(0, 8)));
                    1:       send_char(8'($urandom_range(11, 31)));
                    default: send_char(8'($urandom_range(128, 255)));
                endcase
                sent++;
            end
            else if (choice < 50)
            begin
                // Words the block must drop without effect.
                if ($urandom_range(0, 1) == 1)
                begin
                    w = random_word();
                    w.kind = KIND_UNUSED;
                    send_word(w);
                end
                else
                    send_font(FONT_AW'($urandom_range(FONT_DEPTH, 1023)), 8'($urandom));
            end
            else
            begin
                g = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
                send_char(8'(int'(FIRST_GLYPH) + g));
                sent++;
            end
        end
        @(negedge clk) in_valid <= 1'b0;

        // Drain the owed pixels, then watch for strays.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/tgr_pkg.sv
rtl/tgr_ctrl.sv
rtl/tgr_datapath.sv
rtl/text_glyph_rasterizer_core.sv
rtl/tgr_checker.sv
tb/text_glyph_rasterizer_core_test.sv
